// File: sv/delimited_field_splitter_assert.svh
`ifndef DELIMITED_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITED_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("delimited_field_splitter: check failed");

// next-cycle implication, checked out of reset
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("delimited_field_splitter: check failed");

`endif

// File: sv/dfs_pkg.sv
package dfs_pkg;

  localparam int unsigned MaxSpaceRunDefault = 255;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharComma  = 8'h2C;

  localparam logic [1:0] KindContent   = 2'd0;
  localparam logic [1:0] KindFieldDone = 2'd1;
  localparam logic [1:0] KindLineEmpty = 2'd2;

  localparam logic FuncByte = 1'b0;
  localparam logic FuncEol  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } dfs_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] content_byte;
    logic [7:0] spaces_before;
    logic       line_done;
  } dfs_out_t;

  typedef struct packed {
    logic    valid;
    dfs_in_t data;
  } dfs_stage_t;

  typedef struct packed {
    logic     valid;
    dfs_out_t data;
  } dfs_res_t;

endpackage

// File: sv/dfs_in_reg.sv
module dfs_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dfs_pkg::dfs_in_t    in_data_i,
  input  logic                take_i,
  output dfs_pkg::dfs_stage_t stage_o
);

  logic             valid_q, valid_d;
  dfs_pkg::dfs_in_t data_q, data_d;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// File: sv/dfs_parse.sv
module dfs_parse #(
  parameter int unsigned MaxSpaceRun = dfs_pkg::MaxSpaceRunDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  dfs_pkg::dfs_stage_t stage_i,
  input  logic                sink_full_i,
  output logic                take_o,
  output dfs_pkg::dfs_res_t   res_o
);

  localparam int unsigned LimitInt = (MaxSpaceRun < 255) ? MaxSpaceRun : 255;
  localparam logic [7:0]  Limit    = LimitInt[7:0];

  logic [7:0] delim_q;
  logic       quote_q, quote_d;
  logic       esc_q, esc_d;
  logic       raw_q, raw_d;
  logic       seen_q, seen_d;
  logic [7:0] held_q, held_d;
  logic [7:0] c;

  assign take_o = stage_i.valid && !sink_full_i;
  assign c      = stage_i.data.char_in;

  always_comb begin
    quote_d    = quote_q;
    esc_d      = esc_q;
    raw_d      = raw_q;
    seen_d     = seen_q;
    held_d     = held_q;
    res_o      = '0;
    if (take_o) begin
      if (stage_i.data.func == dfs_pkg::FuncEol) begin
        res_o.valid          = 1'b1;
        res_o.data.kind      = raw_q ? dfs_pkg::KindFieldDone : dfs_pkg::KindLineEmpty;
        res_o.data.line_done = 1'b1;
        quote_d = 1'b0;
        esc_d   = 1'b0;
        raw_d   = 1'b0;
        seen_d  = 1'b0;
        held_d  = '0;
      end else if (!esc_q && c == dfs_pkg::CharQuote) begin
        quote_d = !quote_q;
      end else if (!esc_q && c == dfs_pkg::CharBslash) begin
        esc_d = 1'b1;
      end else if (!esc_q && !quote_q && c == delim_q) begin
        res_o.valid     = 1'b1;
        res_o.data.kind = dfs_pkg::KindFieldDone;
        raw_d  = 1'b0;
        seen_d = 1'b0;
        held_d = '0;
      end else begin
        esc_d = 1'b0;
        raw_d = 1'b1;
        if (c == dfs_pkg::CharSpace) begin
          // hold inner spaces until a non-space byte shows they are not trailing
          if (seen_q && held_q < Limit) begin
            held_d = held_q + 8'd1;
          end
        end else begin
          res_o.valid              = 1'b1;
          res_o.data.kind          = dfs_pkg::KindContent;
          res_o.data.content_byte  = c;
          res_o.data.spaces_before = held_q;
          held_d = '0;
          seen_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= dfs_pkg::CharComma;
      quote_q <= 1'b0;
      esc_q   <= 1'b0;
      raw_q   <= 1'b0;
      seen_q  <= 1'b0;
      held_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_data_i;
      end
      quote_q <= quote_d;
      esc_q   <= esc_d;
      raw_q   <= raw_d;
      seen_q  <= seen_d;
      held_q  <= held_d;
    end
  end

endmodule

// File: sv/dfs_out_fifo.sv
module dfs_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfs_pkg::dfs_res_t push_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dfs_pkg::dfs_out_t out_data_o
);

  localparam logic [1:0] Depth = 2'd2;

  dfs_pkg::dfs_out_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign full_o      = (cnt_q == Depth);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = push_i.valid;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.data;
    end
  end

endmodule

// File: sv/delimited_field_splitter.sv
// Delimited field splitter: one line byte or end-of-line mark per input beat.
// Input channel in_valid_i/in_ready_o carries func and char_in; output channel
// out_valid_o/out_ready_i carries kind, content_byte, spaces_before, line_done.
// Each input beat gives zero or one output beat: content bytes (with the count
// of inner spaces to insert before them), field closes and line closes.
// Write the delimiter through cfg_we_i/cfg_data_i while the block is idle.
// Throughput: one input beat per cycle while the two-entry result buffer has
// room, set by a single decode pass between the input register and the buffer.
// A result goes from the input register through the decode logic into the
// result buffer that offers it; a full buffer keeps it in the input register.
// When the receiver stalls, the result buffer absorbs two beats; after that
// in_ready_o falls once the input register also holds a beat.
// Reset: delimiter returns to comma, quoting, escape and field state clear,
// both channels empty. No clearing pass is needed.
`include "delimited_field_splitter_assert.svh"

module delimited_field_splitter #(
  parameter int unsigned MaxSpaceRun = dfs_pkg::MaxSpaceRunDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfs_pkg::dfs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dfs_pkg::dfs_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i
);

  dfs_pkg::dfs_stage_t stage;
  dfs_pkg::dfs_res_t   res;
  logic                take;
  logic                full;

  dfs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .stage_o    (stage)
  );

  dfs_parse #(
    .MaxSpaceRun (MaxSpaceRun)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .sink_full_i (full),
    .take_o      (take),
    .res_o       (res)
  );

  dfs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `DFS_ASSERT_IMPLIES(a_no_push_when_full, clk_i, rst_ni, res.valid, !full)
  `DFS_ASSERT_IMPLIES(a_stall_holds_beat, clk_i, rst_ni, !in_ready_o, stage.valid && full)
  `DFS_ASSERT_IMPLIES(a_spaces_only_on_content, clk_i, rst_ni, out_valid_o && out_data_o.spaces_before != 8'd0, out_data_o.kind == dfs_pkg::KindContent)
  `DFS_ASSERT_NEXT(a_eol_result_next, clk_i, rst_ni, take && stage.data.func == dfs_pkg::FuncEol, out_valid_o)

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxSpaceRun = dfs_pkg::MaxSpaceRunDefault;

  class field_splitter_scoreboard;
    logic [7:0]        delim;
    bit                in_quote;
    bit                esc_armed;
    bit                field_has_raw;
    bit                seen_text;
    int unsigned       held;
    int unsigned       space_cap;
    int unsigned       errors;
    dfs_pkg::dfs_out_t expected_q[$];

    function new(int unsigned cap);
      space_cap = (cap < 255) ? cap : 255;
      delim = dfs_pkg::CharComma;
      in_quote = 1'b0;
      esc_armed = 1'b0;
      errors = 0;
      clear_field();
    endfunction

    function void clear_field();
      field_has_raw = 1'b0;
      seen_text = 1'b0;
      held = 0;
    endfunction

    function void set_delim(logic [7:0] d);
      delim = d;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void queue_result(dfs_pkg::dfs_out_t r);
      expected_q = {expected_q, r};
    endfunction

    function void note_beat(dfs_pkg::dfs_in_t b);
      dfs_pkg::dfs_out_t r;
      r = '0;
      if (b.func == dfs_pkg::FuncEol) begin
        r.kind = field_has_raw ? dfs_pkg::KindFieldDone : dfs_pkg::KindLineEmpty;
        r.line_done = 1'b1;
        in_quote = 1'b0;
        esc_armed = 1'b0;
        clear_field();
        queue_result(r);
      end else if (!esc_armed && b.char_in == dfs_pkg::CharQuote) begin
        in_quote = !in_quote;
      end else if (!esc_armed && b.char_in == dfs_pkg::CharBslash) begin
        esc_armed = 1'b1;
      end else if (!esc_armed && !in_quote && b.char_in == delim) begin
        clear_field();
        r.kind = dfs_pkg::KindFieldDone;
        queue_result(r);
      end else begin
        esc_armed = 1'b0;
        field_has_raw = 1'b1;
        if (b.char_in == dfs_pkg::CharSpace) begin
          if (seen_text && held < space_cap) held++;
        end else begin
          r.kind = dfs_pkg::KindContent;
          r.content_byte = b.char_in;
          r.spaces_before = 8'(held);
          queue_result(r);
          held = 0;
          seen_text = 1'b1;
        end
      end
    endfunction

    function void mismatch(string fname, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    endfunction

    function void check_result(dfs_pkg::dfs_out_t got);
      dfs_pkg::dfs_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual kind=%0d byte=%02h spaces=%0d done=%0b",
                 $time, got.kind, got.content_byte, got.spaces_before, got.line_done);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) mismatch("kind", want.kind, got.kind);
      if (got.content_byte !== want.content_byte)
        mismatch("content_byte", want.content_byte, got.content_byte);
      if (got.spaces_before !== want.spaces_before)
        mismatch("spaces_before", want.spaces_before, got.spaces_before);
      if (got.line_done !== want.line_done) mismatch("line_done", want.line_done, got.line_done);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  dfs_pkg::dfs_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  dfs_pkg::dfs_out_t out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [7:0]        cfg_data_i = 8'h00;

  field_splitter_scoreboard sb = new(MaxSpaceRun);
  int unsigned items_sent = 0;
  bit          send_quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  delimited_field_splitter #(
    .MaxSpaceRun(MaxSpaceRun)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_beat(in_data_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  initial begin : receiver
    int unsigned stall;
    int unsigned mode_left;
    bit          quiet;
    stall = 0;
    mode_left = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        out_ready_i <= 1'b0;
        stall = pick_gap();
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_beat(input dfs_pkg::dfs_in_t b);
    int unsigned gap;
    gap = send_quiet ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    dfs_pkg::dfs_in_t b;
    b.func = dfs_pkg::FuncByte;
    b.char_in = c;
    send_beat(b);
  endtask

  task automatic send_eol(input logic [7:0] junk);
    dfs_pkg::dfs_in_t b;
    b.func = dfs_pkg::FuncEol;
    b.char_in = junk;
    send_beat(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return sb.delim;
    if (r < 19) return dfs_pkg::CharQuote;
    if (r < 26) return dfs_pkg::CharBslash;
    if (r < 46) return dfs_pkg::CharSpace;
    if (r < 60) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic send_random_line();
    int n;
    int long_at;
    send_quiet = ($urandom_range(0, 3) == 0);
    n = $urandom_range(0, 24);
    long_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 24) : -1;
    for (int k = 0; k < n; k++) begin
      if (k == long_at) begin
        send_char(8'("a" + $urandom_range(0, 25)));
        repeat ($urandom_range(250, 300)) send_char(dfs_pkg::CharSpace);
      end
      send_char(pick_char());
    end
    send_eol(8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) send_random_line();
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_delim(d);
  endtask

  initial begin : stimulus
    logic [7:0] delims[$];
    delims = '{8'h00, 8'hFF, dfs_pkg::CharQuote, dfs_pkg::CharBslash, dfs_pkg::CharSpace,
               8'h3B, 8'h09, 8'($urandom_range(0, 255)), dfs_pkg::CharComma};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_eol(8'hFF);
    send_text(" a  b ,");
    send_eol(8'h00);
    send_text("\"x,y\"\\,\\\"\"\\");
    send_eol(8'h5A);
    send_text(",");
    send_char(8'h00);
    send_char(8'hFF);
    send_eol(8'h00);
    send_text("  ");
    send_eol(8'hA5);

    // hold the output so the block backs up
    send_quiet = 1'b1;
    long_hold_req = 1'b1;
    for (int k = 0; k < 40; k++) send_char(8'("A" + k % 26));
    send_eol(8'h00);

    // saturate the held space count
    send_char("a");
    repeat (300) send_char(dfs_pkg::CharSpace);
    send_char("b");
    send_eol(8'h00);

    run_phase(160);
    foreach (delims[i]) begin
      drain();
      write_delim(delims[i]);
      run_phase(160);
    end
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
